// ----- sv/oetc_pkg.sv -----
// Shared types, codes and reset constants for the evasion tap controller.
package oetc_pkg;

    localparam int TIME_WIDTH_DEF = 32;

    // Configuration register reset values
    localparam logic [15:0] TAP_ON_RST  = 16'd100;
    localparam logic [15:0] TAP_OFF_RST = 16'd200;
    localparam logic [3:0]  MAX_ROT_RST = 4'd10;
    localparam logic [3:0]  MAX_FWD_RST = 4'd8;

    // Configuration register indexes
    localparam logic [1:0] CFG_TAP_ON  = 2'd0;
    localparam logic [1:0] CFG_TAP_OFF = 2'd1;
    localparam logic [1:0] CFG_MAX_ROT = 2'd2;
    localparam logic [1:0] CFG_MAX_FWD = 2'd3;

    // Request function codes
    localparam logic [2:0] FUNC_UPDATE    = 3'd0;
    localparam logic [2:0] FUNC_ALARM_ON  = 3'd1;
    localparam logic [2:0] FUNC_ALARM_OFF = 3'd2;
    localparam logic [2:0] FUNC_TOGGLE    = 3'd3;
    localparam logic [2:0] FUNC_SILENCE   = 3'd4;

    // Obstacle status codes
    localparam logic [2:0] OBS_CLEAR   = 3'd0;
    localparam logic [2:0] OBS_FRONT   = 3'd1;
    localparam logic [2:0] OBS_LEFT    = 3'd2;
    localparam logic [2:0] OBS_RIGHT   = 3'd3;
    localparam logic [2:0] OBS_BOTH    = 3'd4;
    localparam logic [2:0] OBS_REAR    = 3'd5;
    localparam logic [2:0] OBS_TRAPPED = 3'd6;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_ROTATE  = 2'd1,
        MODE_FORWARD = 2'd2,
        MODE_TRAPPED = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        DRV_STOP  = 2'd0,
        DRV_FWD   = 2'd1,
        DRV_LEFT  = 2'd2,
        DRV_RIGHT = 2'd3
    } t_drive;

    typedef enum logic [1:0] {
        SIDE_FRONT = 2'd0,
        SIDE_LEFT  = 2'd1,
        SIDE_RIGHT = 2'd2,
        SIDE_REAR  = 2'd3
    } t_side;

    typedef struct packed {
        logic [15:0] tap_on;
        logic [15:0] tap_off;
        logic [3:0]  max_rot;
        logic [3:0]  max_fwd;
    } t_cfg;

    typedef struct packed {
        logic [2:0] func;
        logic [2:0] obstacle_code;
        logic       is_trapped;
        logic       front_blocked;
        logic       left_blocked;
        logic       right_blocked;
        logic       rear_blocked;
        logic       front_critical;
        logic       prefer_turn_right;
    } t_item;

    typedef struct packed {
        t_mode      mode;
        t_drive     drive;
        logic       tap_start;
        logic [3:0] tap_count;
        logic       alarm_on;
        logic       manual_alarm;
        logic [2:0] last_code;
    } t_result;

endpackage

// ----- sv/oetc_cfg.sv -----
// Configuration register file: tap timing and tap limits.
module oetc_cfg
    import oetc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_en,
    input  logic [1:0]  i_wr_index,
    input  logic [15:0] i_wr_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tap_on  <= TAP_ON_RST;
            r_cfg.tap_off <= TAP_OFF_RST;
            r_cfg.max_rot <= MAX_ROT_RST;
            r_cfg.max_fwd <= MAX_FWD_RST;
        end else if (i_wr_en) begin
            case (i_wr_index)
                CFG_TAP_ON:  r_cfg.tap_on  <= i_wr_data;
                CFG_TAP_OFF: r_cfg.tap_off <= i_wr_data;
                CFG_MAX_ROT: r_cfg.max_rot <= i_wr_data[3:0];
                CFG_MAX_FWD: r_cfg.max_fwd <= i_wr_data[3:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- sv/oetc_core.sv -----
// Evasion state registers and the single-pass next-state logic for one request.
module oetc_core
    import oetc_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  t_item                 i_item,
    input  logic [TIME_WIDTH-1:0] i_now,
    input  t_cfg                  i_cfg,
    output t_result               o_res
);

    t_mode                 r_mode, n_mode;
    logic                  r_rest, n_rest;
    t_drive                r_dir, n_dir;
    t_side                 r_side, n_side;
    logic [TIME_WIDTH-1:0] r_phase, n_phase;
    logic [3:0]            r_count, n_count;
    logic                  r_auto, n_auto;
    logic                  r_manual, n_manual;
    logic                  r_silenced, n_silenced;
    logic [2:0]            r_status, n_status;
    t_drive                r_drive, n_drive;

    logic [TIME_WIDTH-1:0] elapsed;
    logic [3:0]            limit;
    logic                  cleared;
    logic                  started;
    t_drive                flank;
    logic                  alarm_now;

    // Wrapping difference is the elapsed time
    assign elapsed   = i_now - r_phase;
    assign limit     = (r_mode == MODE_FORWARD) ? i_cfg.max_fwd : i_cfg.max_rot;
    assign flank     = i_item.prefer_turn_right ? DRV_RIGHT : DRV_LEFT;
    assign alarm_now = r_manual | (r_auto & ~r_silenced);

    always_comb begin
        if (r_mode == MODE_FORWARD) begin
            cleared = i_item.front_critical | ~i_item.rear_blocked;
        end else begin
            case (r_side)
                SIDE_LEFT:  cleared = ~i_item.left_blocked;
                SIDE_RIGHT: cleared = ~i_item.right_blocked;
                default:    cleared = ~i_item.front_blocked;
            endcase
        end
    end

    always_comb begin
        n_mode     = r_mode;
        n_rest     = r_rest;
        n_dir      = r_dir;
        n_side     = r_side;
        n_phase    = r_phase;
        n_count    = r_count;
        n_auto     = r_auto;
        n_manual   = r_manual;
        n_silenced = r_silenced;
        n_status   = r_status;
        n_drive    = r_drive;
        started    = 1'b0;

        case (i_item.func)
            FUNC_UPDATE: begin
                n_status = i_item.obstacle_code;
                case (r_mode)
                    MODE_IDLE: begin
                        n_drive = DRV_STOP;
                        n_count = 4'd0;
                        if (i_item.obstacle_code == OBS_TRAPPED || i_item.is_trapped) begin
                            n_mode  = MODE_TRAPPED;
                            n_auto  = 1'b1;
                            n_phase = i_now;
                        end else begin
                            n_auto     = 1'b0;
                            n_silenced = 1'b0;
                            started    = 1'b1;
                            n_mode     = MODE_ROTATE;
                            n_side     = SIDE_FRONT;
                            n_dir      = flank;
                            case (i_item.obstacle_code)
                                OBS_REAR: begin
                                    if (!i_item.front_blocked) begin
                                        n_mode = MODE_FORWARD;
                                        n_dir  = DRV_FWD;
                                        n_side = SIDE_REAR;
                                    end
                                end
                                OBS_LEFT: begin
                                    n_dir  = DRV_RIGHT;
                                    n_side = SIDE_LEFT;
                                end
                                OBS_RIGHT: begin
                                    n_dir  = DRV_LEFT;
                                    n_side = SIDE_RIGHT;
                                end
                                OBS_FRONT, OBS_BOTH: ;
                                default: started = 1'b0;
                            endcase
                            if (started) begin
                                n_rest  = 1'b0;
                                n_count = 4'd1;
                                n_phase = i_now;
                                n_drive = n_dir;
                            end else begin
                                n_mode = MODE_IDLE;
                                n_dir  = r_dir;
                                n_side = r_side;
                            end
                        end
                    end
                    MODE_ROTATE, MODE_FORWARD: begin
                        if (!r_rest) begin
                            if (elapsed >= TIME_WIDTH'(i_cfg.tap_on)) begin
                                n_drive = DRV_STOP;
                                n_rest  = 1'b1;
                                n_phase = i_now;
                            end
                        end else if (elapsed >= TIME_WIDTH'(i_cfg.tap_off)) begin
                            if (cleared) begin
                                n_drive = DRV_STOP;
                                n_mode  = MODE_IDLE;
                                n_count = 4'd0;
                            end else if (i_item.is_trapped) begin
                                n_drive = DRV_STOP;
                                n_mode  = MODE_TRAPPED;
                                n_auto  = 1'b1;
                                n_count = 4'd0;
                            end else if (r_count >= limit) begin
                                n_drive = DRV_STOP;
                                n_mode  = MODE_IDLE;
                                n_count = 4'd0;
                            end else begin
                                n_count = r_count + 4'd1;
                                n_rest  = 1'b0;
                                n_phase = i_now;
                                n_drive = r_dir;
                                started = 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_drive = DRV_STOP;
                        if (!i_item.is_trapped) begin
                            n_mode     = MODE_IDLE;
                            n_auto     = 1'b0;
                            n_silenced = 1'b0;
                        end else begin
                            n_auto = 1'b1;
                        end
                    end
                endcase
            end
            FUNC_ALARM_ON: begin
                n_manual   = 1'b1;
                n_silenced = 1'b0;
            end
            FUNC_ALARM_OFF: n_manual = 1'b0;
            FUNC_TOGGLE: begin
                n_manual   = ~alarm_now;
                n_silenced = alarm_now;
            end
            FUNC_SILENCE: begin
                n_manual   = 1'b0;
                n_silenced = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_rest     <= 1'b0;
            r_dir      <= DRV_STOP;
            r_side     <= SIDE_FRONT;
            r_phase    <= '0;
            r_count    <= 4'd0;
            r_auto     <= 1'b0;
            r_manual   <= 1'b0;
            r_silenced <= 1'b0;
            r_status   <= OBS_CLEAR;
            r_drive    <= DRV_STOP;
        end else if (i_fire) begin
            r_mode     <= n_mode;
            r_rest     <= n_rest;
            r_dir      <= n_dir;
            r_side     <= n_side;
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_auto     <= n_auto;
            r_manual   <= n_manual;
            r_silenced <= n_silenced;
            r_status   <= n_status;
            r_drive    <= n_drive;
        end
    end

    always_comb begin
        o_res.mode         = n_mode;
        o_res.drive        = n_drive;
        o_res.tap_start    = started;
        o_res.tap_count    = n_count;
        o_res.alarm_on     = n_manual | (n_auto & ~n_silenced);
        o_res.manual_alarm = n_manual;
        o_res.last_code    = n_status;
    end

endmodule

// ----- sv/obstacle_evasion_tap_controller.sv -----
// Top level: request input register, evasion core, result register and handshakes.
// A request is captured in the input register and its result in the result register.
// Throughput: one request per cycle unless the result stalls; the core decides in a
// single combinational pass between the input register and the result register.
// Reset (synchronous, active low): idle mode, motor stopped, alarms off, counters zero,
// configuration back to 100 ms on, 200 ms off, limits 10 rotate and 8 forward taps.
module obstacle_evasion_tap_controller
    import oetc_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [2:0]            i_func,
    input  logic [TIME_WIDTH-1:0] i_now_ms,
    input  logic [2:0]            i_obstacle_code,
    input  logic                  i_is_trapped,
    input  logic                  i_front_blocked,
    input  logic                  i_left_blocked,
    input  logic                  i_right_blocked,
    input  logic                  i_rear_blocked,
    input  logic                  i_front_critical,
    input  logic                  i_prefer_turn_right,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_evade_mode,
    output logic [1:0]            o_motor_drive,
    output logic                  o_tap_start,
    output logic [3:0]            o_tap_count,
    output logic                  o_alarm_on,
    output logic                  o_manual_alarm_on,
    output logic [2:0]            o_last_obstacle_code,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [15:0]           i_cfg_data
);

    logic                  r_in_vld;
    t_item                 r_in_item;
    logic [TIME_WIDTH-1:0] r_in_now;
    logic                  r_out_vld;
    t_result               r_out_res;

    logic    advance;
    logic    fire;
    t_cfg    cfg;
    t_result res;

    assign advance     = ~r_out_vld | ~i_out_stall;
    assign fire        = r_in_vld & advance;
    assign o_in_stall  = r_in_vld & ~advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_vld <= i_in_valid;
            end
            if (advance) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item.func              <= i_func;
            r_in_item.obstacle_code     <= i_obstacle_code;
            r_in_item.is_trapped        <= i_is_trapped;
            r_in_item.front_blocked     <= i_front_blocked;
            r_in_item.left_blocked      <= i_left_blocked;
            r_in_item.right_blocked     <= i_right_blocked;
            r_in_item.rear_blocked      <= i_rear_blocked;
            r_in_item.front_critical    <= i_front_critical;
            r_in_item.prefer_turn_right <= i_prefer_turn_right;
            r_in_now                    <= i_now_ms;
        end
        if (fire) begin
            r_out_res <= res;
        end
    end

    oetc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid & o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    oetc_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in_item),
        .i_now   (r_in_now),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    assign o_out_valid          = r_out_vld;
    assign o_evade_mode         = r_out_res.mode;
    assign o_motor_drive        = r_out_res.drive;
    assign o_tap_start          = r_out_res.tap_start;
    assign o_tap_count          = r_out_res.tap_count;
    assign o_alarm_on           = r_out_res.alarm_on;
    assign o_manual_alarm_on    = r_out_res.manual_alarm;
    assign o_last_obstacle_code = r_out_res.last_code;

    // A new pulse only starts in a tapping mode and always drives the motor
    a_tap_start_drives: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_tap_start) |->
            (o_motor_drive != DRV_STOP &&
             (o_evade_mode == MODE_ROTATE || o_evade_mode == MODE_FORWARD)))
        else $error("tap start without drive or outside a tapping mode");

    // The tap count is cleared whenever the controller leaves the tapping modes
    a_count_in_tapping: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_tap_count == 4'd0 || o_evade_mode == MODE_ROTATE ||
             o_evade_mode == MODE_FORWARD))
        else $error("tap count held outside a tapping mode");

    // The input side stalls only behind a result that is itself held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("request stalled with result register free");

    // A result held under stall does not change
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_evade_mode) && $stable(o_tap_count) &&
             $stable(o_motor_drive)))
        else $error("stalled result changed");

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the obstacle evasion tap controller.
`timescale 1ns / 100ps

module testbench;
    import oetc_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    // func codes outside the defined set
    localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
    localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;
    localparam logic [2:0] OBS_UNDEF      = 3'd7;

    // sensor flag bits, in request field order
    localparam logic [6:0] F_TRAP  = 7'b1000000;
    localparam logic [6:0] F_FRONT = 7'b0100000;
    localparam logic [6:0] F_LEFT  = 7'b0010000;
    localparam logic [6:0] F_RIGHT = 7'b0001000;
    localparam logic [6:0] F_REAR  = 7'b0000100;
    localparam logic [6:0] F_CRIT  = 7'b0000010;
    localparam logic [6:0] F_PREFR = 7'b0000001;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_func;
    logic [31:0] i_now_ms;
    logic [2:0]  i_obstacle_code;
    logic        i_is_trapped;
    logic        i_front_blocked;
    logic        i_left_blocked;
    logic        i_right_blocked;
    logic        i_rear_blocked;
    logic        i_front_critical;
    logic        i_prefer_turn_right;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_evade_mode;
    logic [1:0]  o_motor_drive;
    logic        o_tap_start;
    logic [3:0]  o_tap_count;
    logic        o_alarm_on;
    logic        o_manual_alarm_on;
    logic [2:0]  o_last_obstacle_code;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    obstacle_evasion_tap_controller dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_func               (i_func),
        .i_now_ms             (i_now_ms),
        .i_obstacle_code      (i_obstacle_code),
        .i_is_trapped         (i_is_trapped),
        .i_front_blocked      (i_front_blocked),
        .i_left_blocked       (i_left_blocked),
        .i_right_blocked      (i_right_blocked),
        .i_rear_blocked       (i_rear_blocked),
        .i_front_critical     (i_front_critical),
        .i_prefer_turn_right  (i_prefer_turn_right),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_evade_mode         (o_evade_mode),
        .o_motor_drive        (o_motor_drive),
        .o_tap_start          (o_tap_start),
        .o_tap_count          (o_tap_count),
        .o_alarm_on           (o_alarm_on),
        .o_manual_alarm_on    (o_manual_alarm_on),
        .o_last_obstacle_code (o_last_obstacle_code),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    // Predictor copy of the controller state and configuration
    t_mode       m_mode     = MODE_IDLE;
    logic        m_rest     = 1'b0;
    t_drive      m_dir      = DRV_STOP;
    t_side       m_side     = SIDE_FRONT;
    logic [31:0] m_phase_t  = '0;
    logic [3:0]  m_taps     = '0;
    logic        m_auto     = 1'b0;
    logic        m_manual   = 1'b0;
    logic        m_silenced = 1'b0;
    logic [2:0]  m_status   = OBS_CLEAR;
    t_drive      m_drive    = DRV_STOP;
    logic [15:0] c_on       = TAP_ON_RST;
    logic [15:0] c_off      = TAP_OFF_RST;
    logic [3:0]  c_rot      = MAX_ROT_RST;
    logic [3:0]  c_fwd      = MAX_FWD_RST;

    t_result     pending_results[$];
    t_result     want_res;
    int          n_errors    = 0;
    int          cycle_count = 0;
    int          gap_max     = 15;
    int          stall_max   = 15;
    int          hold_cycles = 0;
    logic [31:0] clock_ms    = '0;

    function automatic logic alarm_active();
        return m_manual | (m_auto & ~m_silenced);
    endfunction

    function automatic void begin_tap(t_mode mode, t_drive dir, t_side side,
                                      logic [31:0] now);
        m_mode    = mode;
        m_rest    = 1'b0;
        m_dir     = dir;
        m_side    = side;
        m_taps    = 4'd1;
        m_phase_t = now;
        m_drive   = dir;
    endfunction

    // pulse/rest sequencing, returns 1 when a new pulse starts
    function automatic logic tap_sequence(logic [31:0] now, logic cleared, logic trapped,
                                          logic [3:0] limit);
        logic [31:0] elapsed;
        elapsed = now - m_phase_t;
        if (!m_rest) begin
            if (elapsed >= {16'd0, c_on}) begin
                m_drive   = DRV_STOP;
                m_rest    = 1'b1;
                m_phase_t = now;
            end
            return 1'b0;
        end
        if (elapsed < {16'd0, c_off})
            return 1'b0;
        if (cleared) begin
            m_drive = DRV_STOP;
            m_mode  = MODE_IDLE;
            m_taps  = 4'd0;
        end else if (trapped) begin
            m_drive = DRV_STOP;
            m_mode  = MODE_TRAPPED;
            m_auto  = 1'b1;
            m_taps  = 4'd0;
        end else if (m_taps >= limit) begin
            m_drive = DRV_STOP;
            m_mode  = MODE_IDLE;
            m_taps  = 4'd0;
        end else begin
            m_taps    = m_taps + 4'd1;
            m_rest    = 1'b0;
            m_phase_t = now;
            m_drive   = m_dir;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic evasion_update(t_item req, logic [31:0] now);
        t_drive flank;
        logic   started;
        logic   cleared;
        flank    = req.prefer_turn_right ? DRV_RIGHT : DRV_LEFT;
        started  = 1'b0;
        m_status = req.obstacle_code;
        case (m_mode)
            MODE_IDLE: begin
                m_drive = DRV_STOP;
                m_taps  = 4'd0;
                if (req.obstacle_code == OBS_TRAPPED || req.is_trapped) begin
                    m_mode    = MODE_TRAPPED;
                    m_auto    = 1'b1;
                    m_phase_t = now;
                end else begin
                    m_auto     = 1'b0;
                    m_silenced = 1'b0;
                    started    = 1'b1;
                    case (req.obstacle_code)
                        OBS_REAR: begin
                            if (!req.front_blocked)
                                begin_tap(MODE_FORWARD, DRV_FWD, SIDE_REAR, now);
                            else
                                begin_tap(MODE_ROTATE, flank, SIDE_FRONT, now);
                        end
                        OBS_LEFT:  begin_tap(MODE_ROTATE, DRV_RIGHT, SIDE_LEFT, now);
                        OBS_RIGHT: begin_tap(MODE_ROTATE, DRV_LEFT, SIDE_RIGHT, now);
                        OBS_FRONT, OBS_BOTH: begin_tap(MODE_ROTATE, flank, SIDE_FRONT, now);
                        default: started = 1'b0;
                    endcase
                end
            end
            MODE_ROTATE: begin
                if (m_side == SIDE_LEFT)
                    cleared = ~req.left_blocked;
                else if (m_side == SIDE_RIGHT)
                    cleared = ~req.right_blocked;
                else
                    cleared = ~req.front_blocked;
                started = tap_sequence(now, cleared, req.is_trapped, c_rot);
            end
            MODE_FORWARD: begin
                started = tap_sequence(now, req.front_critical | ~req.rear_blocked,
                                       req.is_trapped, c_fwd);
            end
            default: begin
                m_drive = DRV_STOP;
                if (!req.is_trapped) begin
                    m_mode     = MODE_IDLE;
                    m_auto     = 1'b0;
                    m_silenced = 1'b0;
                end else begin
                    m_auto = 1'b1;
                end
            end
        endcase
        return started;
    endfunction

    function automatic t_result predict_response(t_item req, logic [31:0] now);
        t_result res;
        logic    started;
        started = 1'b0;
        case (req.func)
            FUNC_UPDATE:    started = evasion_update(req, now);
            FUNC_ALARM_ON:  begin m_manual = 1'b1; m_silenced = 1'b0; end
            FUNC_ALARM_OFF: m_manual = 1'b0;
            FUNC_TOGGLE: begin
                if (alarm_active()) begin
                    m_manual   = 1'b0;
                    m_silenced = 1'b1;
                end else begin
                    m_manual   = 1'b1;
                    m_silenced = 1'b0;
                end
            end
            FUNC_SILENCE:   begin m_manual = 1'b0; m_silenced = 1'b1; end
            default: ;
        endcase
        res.mode         = m_mode;
        res.drive        = m_drive;
        res.tap_start    = started;
        res.tap_count    = m_taps;
        res.alarm_on     = alarm_active();
        res.manual_alarm = m_manual;
        res.last_code    = m_status;
        return res;
    endfunction

    function automatic t_item make_req(logic [2:0] fn, logic [2:0] code, logic [6:0] flags);
        t_item req;
        req = {fn, code, flags};
        return req;
    endfunction

    function automatic logic chance(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic void check_field(string name, logic [3:0] want, logic [3:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Result side: random stall per result, plus an optional long hold-off
    initial begin
        int w;
        i_out_stall <= 1'b0;
        forever begin
            if (hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end
            w = $urandom_range(0, stall_max);
            if (w > 0) begin
                i_out_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding");
                n_errors++;
            end else begin
                want_res = pending_results.pop_front();
                check_field("evade_mode", want_res.mode, o_evade_mode);
                check_field("motor_drive", want_res.drive, o_motor_drive);
                check_field("tap_start", want_res.tap_start, o_tap_start);
                check_field("tap_count", want_res.tap_count, o_tap_count);
                check_field("alarm_on", want_res.alarm_on, o_alarm_on);
                check_field("manual_alarm_on", want_res.manual_alarm, o_manual_alarm_on);
                check_field("last_obstacle_code", want_res.last_code,
                            o_last_obstacle_code);
            end
        end
    end

    // Called just after a rising edge; leaves valid high after acceptance
    task automatic send_request(input t_item req, input logic [31:0] now);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_func              <= req.func;
        i_now_ms            <= now;
        i_obstacle_code     <= req.obstacle_code;
        i_is_trapped        <= req.is_trapped;
        i_front_blocked     <= req.front_blocked;
        i_left_blocked      <= req.left_blocked;
        i_right_blocked     <= req.right_blocked;
        i_rear_blocked      <= req.rear_blocked;
        i_front_critical    <= req.front_critical;
        i_prefer_turn_right <= req.prefer_turn_right;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        pending_results.push_back(predict_response(req, now));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_TAP_ON:  c_on  = value;
            CFG_TAP_OFF: c_off = value;
            CFG_MAX_ROT: c_rot = value[3:0];
            CFG_MAX_FWD: c_fwd = value[3:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // limit registers get junk in the unused upper bits
    task automatic set_config(input logic [15:0] on, input logic [15:0] off,
                              input logic [3:0] rot, input logic [3:0] fwd);
        drain_results();
        write_reg(CFG_TAP_ON, on);
        write_reg(CFG_TAP_OFF, off);
        write_reg(CFG_MAX_ROT, {12'($urandom), rot});
        write_reg(CFG_MAX_FWD, {12'($urandom), fwd});
    endtask

    task automatic send_random(input int n);
        t_item       req;
        int          r;
        int          span;
        logic [31:0] step;
        logic [31:0] now;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 86)
                req.func = FUNC_UPDATE;
            else if (r < 96)
                req.func = 3'($urandom_range(FUNC_ALARM_ON, FUNC_SILENCE));
            else
                req.func = 3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
            r = $urandom_range(0, 99);
            if (r < 8)
                req.obstacle_code = OBS_TRAPPED;
            else if (r < 13)
                req.obstacle_code = OBS_UNDEF;
            else if (r < 23)
                req.obstacle_code = OBS_CLEAR;
            else
                req.obstacle_code = 3'($urandom_range(OBS_FRONT, OBS_REAR));
            req.is_trapped        = chance(4);
            req.front_blocked     = chance(80);
            req.left_blocked      = chance(80);
            req.right_blocked     = chance(80);
            req.rear_blocked      = chance(85);
            req.front_critical    = chance(10);
            req.prefer_turn_right = chance(50);
            if (req.func == FUNC_UPDATE) begin
                span = (c_on > c_off) ? c_on : c_off;
                r = $urandom_range(0, 99);
                if (r < 4)
                    step = $urandom;
                else if (r < 14)
                    step = '0;
                else if (r < 34)
                    step = {16'd0, c_on};
                else if (r < 54)
                    step = {16'd0, c_off};
                else
                    step = $urandom_range(0, span + 1);
                clock_ms = clock_ms + step;
                now = clock_ms;
            end else begin
                now = $urandom;
            end
            send_request(req, now);
        end
    endtask

    task automatic test_directed();
        logic [31:0] t;
        t = 32'd1000;
        for (int f = FUNC_UNUSED_LO; f <= FUNC_UNUSED_HI; f++)
            send_request(make_req(3'(f), OBS_UNDEF, 7'h7F), 32'hFFFF_FFFF);
        send_request(make_req(FUNC_ALARM_ON, OBS_CLEAR, '0), t);
        send_request(make_req(FUNC_TOGGLE, OBS_CLEAR, '0), t);
        send_request(make_req(FUNC_TOGGLE, OBS_CLEAR, '0), t);
        send_request(make_req(FUNC_ALARM_OFF, OBS_CLEAR, '0), t);
        // trapped entry, silence, stay trapped, release
        send_request(make_req(FUNC_UPDATE, OBS_TRAPPED, '0), t);
        send_request(make_req(FUNC_SILENCE, OBS_CLEAR, '0), t);
        send_request(make_req(FUNC_UPDATE, OBS_CLEAR, F_TRAP), t + 5);
        send_request(make_req(FUNC_UPDATE, OBS_CLEAR, '0), t + 6);
        send_request(make_req(FUNC_UPDATE, OBS_UNDEF, '0), t + 7);
        // left threat: pulse, rest, second tap, then cleared
        send_request(make_req(FUNC_UPDATE, OBS_LEFT, '0), t);
        send_request(make_req(FUNC_UPDATE, OBS_CLEAR, F_LEFT), t + 99);
        send_request(make_req(FUNC_UPDATE, OBS_CLEAR, F_LEFT), t + 100);
        send_request(make_req(FUNC_UPDATE, OBS_CLEAR, F_LEFT), t + 300);
        send_request(make_req(FUNC_UPDATE, OBS_CLEAR, F_LEFT), t + 400);
        send_request(make_req(FUNC_UPDATE, OBS_CLEAR, '0), t + 600);
        // rear threat with front open: forward taps, cleared by front critical
        send_request(make_req(FUNC_UPDATE, OBS_REAR, F_REAR), t);
        send_request(make_req(FUNC_UPDATE, OBS_REAR, F_REAR), t + 100);
        send_request(make_req(FUNC_UPDATE, OBS_REAR, F_REAR | F_CRIT), t + 300);
        // front threat turning right, trapped after rest
        send_request(make_req(FUNC_UPDATE, OBS_FRONT, F_PREFR), t);
        send_request(make_req(FUNC_UPDATE, OBS_FRONT, F_FRONT), t + 100);
        send_request(make_req(FUNC_UPDATE, OBS_FRONT, F_FRONT | F_TRAP), t + 300);
        send_request(make_req(FUNC_UPDATE, OBS_CLEAR, '0), t + 301);
        // time stamp wrapping during the pulse
        t = 32'hFFFF_FFC0;
        send_request(make_req(FUNC_UPDATE, OBS_BOTH, F_FRONT), t);
        send_request(make_req(FUNC_UPDATE, OBS_BOTH, F_FRONT), t + 100);
        send_request(make_req(FUNC_UPDATE, OBS_RIGHT, F_FRONT | F_RIGHT), t + 300);
        send_request(make_req(FUNC_UPDATE, OBS_REAR, F_FRONT | F_RIGHT), t + 500);
    endtask

    task automatic test_config_extremes();
        logic [31:0] t;
        t = 32'h8000_0000;
        // zero durations and zero limits
        set_config(16'd0, 16'd0, 4'd0, 4'd0);
        send_request(make_req(FUNC_UPDATE, OBS_RIGHT, F_RIGHT), t);
        send_request(make_req(FUNC_UPDATE, OBS_RIGHT, F_RIGHT), t);
        send_request(make_req(FUNC_UPDATE, OBS_RIGHT, F_RIGHT), t);
        send_request(make_req(FUNC_UPDATE, OBS_REAR, F_REAR), t);
        send_request(make_req(FUNC_UPDATE, OBS_REAR, F_REAR), t);
        send_request(make_req(FUNC_UPDATE, OBS_REAR, F_REAR), t);
        // longest runs up to the top tap limit
        set_config(16'd0, 16'd0, 4'd15, 4'd15);
        send_request(make_req(FUNC_UPDATE, OBS_LEFT, F_LEFT), t);
        for (int i = 0; i < 34; i++)
            send_request(make_req(FUNC_UPDATE, OBS_CLEAR, F_LEFT), t);
        send_request(make_req(FUNC_UPDATE, OBS_REAR, F_REAR), t);
        for (int i = 0; i < 34; i++)
            send_request(make_req(FUNC_UPDATE, OBS_CLEAR, F_REAR), t);
        // longest durations, across the wrap
        set_config(16'hFFFF, 16'hFFFF, 4'd15, 4'd15);
        t = 32'hFFFF_8000;
        send_request(make_req(FUNC_UPDATE, OBS_FRONT, F_FRONT), t);
        send_request(make_req(FUNC_UPDATE, OBS_FRONT, F_FRONT), t + 32'hFFFE);
        send_request(make_req(FUNC_UPDATE, OBS_FRONT, F_FRONT), t + 32'hFFFF);
        send_request(make_req(FUNC_UPDATE, OBS_FRONT, F_FRONT), t + 32'h1FFFE);
        send_request(make_req(FUNC_UPDATE, OBS_FRONT, F_FRONT), t + 32'h1FFFF);
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: set_config(TAP_ON_RST, TAP_OFF_RST, MAX_ROT_RST, MAX_FWD_RST);
                1: set_config(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                              4'($urandom_range(1, 15)), 4'($urandom_range(1, 15)));
                2: set_config(16'hFFFF, 16'hFFFF, 4'd15, 4'd15);
                3: set_config(16'd1, 16'd1, 4'd1, 4'd1);
                4: set_config(16'($urandom), 16'($urandom), 4'($urandom), 4'($urandom));
                default: set_config(16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)),
                                    4'($urandom_range(1, 15)), 4'($urandom_range(1, 15)));
            endcase
            // no idling on either side in one phase
            gap_max   = (p == 1) ? 0 : 15;
            stall_max = (p == 1) ? 0 : 15;
            clock_ms  = (p == 2) ? 32'hFFFF_FFFF - $urandom_range(0, 2000) : $urandom;
            send_random(233);
        end
    endtask

    task automatic test_backpressure();
        gap_max     = 0;
        stall_max   = 0;
        hold_cycles = 60;
        send_random(40);
        gap_max   = 15;
        stall_max = 15;
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        i_in_valid          <= 1'b0;
        i_func              <= FUNC_UPDATE;
        i_now_ms            <= '0;
        i_obstacle_code     <= OBS_CLEAR;
        i_is_trapped        <= 1'b0;
        i_front_blocked     <= 1'b0;
        i_left_blocked      <= 1'b0;
        i_right_blocked     <= 1'b0;
        i_rear_blocked      <= 1'b0;
        i_front_critical    <= 1'b0;
        i_prefer_turn_right <= 1'b0;
        i_cfg_valid         <= 1'b0;
        i_cfg_index         <= CFG_TAP_ON;
        i_cfg_data          <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_config_extremes();
        test_random_phases();
        test_backpressure();

        drain_results();
        repeat (8) @(posedge i_clk);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/oetc_pkg.sv
sv/oetc_cfg.sv
sv/oetc_core.sv
sv/obstacle_evasion_tap_controller.sv
tb/sv/testbench.sv
